/* rtl/core/iss_pkg.sv */
package iss_pkg;

  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int DATA_W = 32;
  localparam int CMD_W  = 3;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 104;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND    = 3'd0,
    CMD_PREPEND   = 3'd1,
    CMD_DEL_FIRST = 3'd2,
    CMD_DEL_LAST  = 3'd3,
    CMD_DEL_AT    = 3'd4,
    CMD_INS_AT    = 3'd5,
    CMD_READ      = 3'd6,
    CMD_WRITE     = 3'd7
  } cmd_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic publish;
  } ctl_t;

  typedef struct packed {
    logic out_valid;
  } sts_t;

endpackage

/* rtl/core/iss_ctrl.sv */
module iss_ctrl
  import iss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  logic out_tready,
  input  sts_t sts,
  output ctl_t ctl,
  output logic out_valid_nxt
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready   = (state_r == ST_IDLE);
  assign ctl.load    = in_tready && in_tvalid;
  assign ctl.exec    = (state_r == ST_EXEC);
  assign ctl.publish = (state_r == ST_FIN) && (!sts.out_valid || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (ctl.load) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_FIN;
      ST_FIN:  if (ctl.publish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (ctl.publish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = sts.out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/core/iss_dpath.sv */
module iss_dpath
  import iss_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  ctl_t                     ctl,
  input  logic                     out_valid_nxt,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [DATA_W-1:0] in_item_value,
  output sts_t                     sts,
  output logic                     res_ok,
  output logic signed [DATA_W-1:0] res_data,
  output logic [CNT_W-1:0]         res_count,
  output logic signed [DATA_W-1:0] res_head,
  output logic signed [DATA_W-1:0] res_tail,
  output logic                     res_empty
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  cmd_t               cmd_r;
  logic [POS_W-1:0]   pos_r;
  logic [DATA_W-1:0]  val_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [DATA_W-1:0]  cells_r [DEPTH];
  logic [DATA_W-1:0]  cells_nxt [DEPTH];
  logic               ok_r, ok_nxt;
  logic [DATA_W-1:0]  data_r;
  logic               out_valid_r;

  logic [AW-1:0]      rd_idx;
  logic [DATA_W-1:0]  rd_data;
  logic [AW-1:0]      last_idx;
  logic [CMPW-1:0]    pe, ce, ins_p, del_p;
  logic               full, nonempty;

  assign sts.out_valid = out_valid_r;

  assign pe       = CMPW'(pos_r);
  assign ce       = CMPW'(cnt_r);
  assign full     = (cnt_r == CW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign last_idx = AW'(cnt_r - CW'(1));
  assign ins_p    = (cmd_r == CMD_PREPEND) ? '0 : pe;
  assign del_p    = (cmd_r == CMD_DEL_FIRST) ? '0 : pe;

  always_comb begin
    rd_idx = AW'(pos_r);
    if (ctl.exec) begin
      unique case (cmd_r)
        CMD_DEL_FIRST: rd_idx = '0;
        CMD_DEL_LAST:  rd_idx = last_idx;
        default:       rd_idx = AW'(pos_r);
      endcase
    end else begin
      rd_idx = last_idx;
    end
  end

  assign rd_data = cells_r[rd_idx];

  always_comb begin
    unique case (cmd_r)
      CMD_APPEND, CMD_PREPEND:   ok_nxt = !full;
      CMD_DEL_FIRST, CMD_DEL_LAST: ok_nxt = nonempty;
      CMD_INS_AT:                ok_nxt = !full && (pe <= ce);
      default:                   ok_nxt = (pe < ce);
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    for (int k = 0; k < DEPTH; k++) begin
      cells_nxt[k] = cells_r[k];
    end
    if (ok_nxt) begin
      unique case (cmd_r)
        CMD_APPEND: begin
          cnt_nxt = cnt_r + CW'(1);
          for (int k = 0; k < DEPTH; k++) begin
            if (CMPW'(k) == ce) cells_nxt[k] = val_r;
          end
        end
        CMD_PREPEND, CMD_INS_AT: begin
          cnt_nxt = cnt_r + CW'(1);
          for (int k = 0; k < DEPTH; k++) begin
            if (CMPW'(k) == ins_p) begin
              cells_nxt[k] = val_r;
            end else if (k > 0) begin
              if (CMPW'(k) > ins_p) cells_nxt[k] = cells_r[k-1];
            end
          end
        end
        CMD_DEL_FIRST, CMD_DEL_AT: begin
          cnt_nxt = cnt_r - CW'(1);
          for (int k = 0; k < DEPTH - 1; k++) begin
            if (CMPW'(k) >= del_p) cells_nxt[k] = cells_r[k+1];
          end
        end
        CMD_DEL_LAST: begin
          cnt_nxt = cnt_r - CW'(1);
        end
        CMD_READ: begin
          cnt_nxt = cnt_r;
        end
        CMD_WRITE: begin
          for (int k = 0; k < DEPTH; k++) begin
            if (CMPW'(k) == pe) cells_nxt[k] = val_r;
          end
        end
        default: cnt_nxt = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctl.exec) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd_t'(in_cmd);
      pos_r <= in_position;
      val_r <= in_item_value;
    end
    if (ctl.exec) begin
      for (int k = 0; k < DEPTH; k++) begin
        cells_r[k] <= cells_nxt[k];
      end
      ok_r   <= ok_nxt;
      data_r <= (ok_nxt && (cmd_r != CMD_APPEND) && (cmd_r != CMD_PREPEND) &&
                 (cmd_r != CMD_INS_AT) && (cmd_r != CMD_WRITE)) ? rd_data : '0;
    end
    if (ctl.publish) begin
      res_ok    <= ok_r;
      res_data  <= data_r;
      res_count <= CNT_W'(cnt_r);
      res_head  <= nonempty ? cells_r[0] : '0;
      res_tail  <= nonempty ? rd_data : '0;
      res_empty <= !nonempty;
    end
  end

endmodule

/* rtl/core/indexed_sequence_store.sv */
// Ordered store of up to DEPTH signed 32-bit values driven by one command per
// request (append, prepend, delete first/last/at, insert at, read, write); every
// request returns one result with a success flag, the value read or removed, the
// new count, head, tail and an empty flag. A request is handled in steps: capture,
// a parallel shift of the slot cells with the count update, then a tail read
// through the slot read port that loads the output register. The next request
// is accepted only once that register is loaded; a stalled result holds the
// block in its final step.
module indexed_sequence_store
  import iss_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // position[4:0], item_value[36:5], zero pad
  input  logic [CMD_W-1:0]       in_tuser,   // cmd[2:0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // ok, data_out, count, head_value,
                                             // tail_value, is_empty, zero pad
);

  ctl_t ctl;
  sts_t sts;
  logic out_valid_nxt;

  logic                     res_ok;
  logic signed [DATA_W-1:0] res_data;
  logic [CNT_W-1:0]         res_count;
  logic signed [DATA_W-1:0] res_head;
  logic signed [DATA_W-1:0] res_tail;
  logic                     res_empty;

  iss_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .out_tready    (out_tready),
    .sts           (sts),
    .ctl           (ctl),
    .out_valid_nxt (out_valid_nxt)
  );

  iss_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .out_valid_nxt (out_valid_nxt),
    .in_cmd        (in_tuser),
    .in_position   (in_tdata[POS_W-1:0]),
    .in_item_value (in_tdata[POS_W+DATA_W-1:POS_W]),
    .sts           (sts),
    .res_ok        (res_ok),
    .res_data      (res_data),
    .res_count     (res_count),
    .res_head      (res_head),
    .res_tail      (res_tail),
    .res_empty     (res_empty)
  );

  assign out_tvalid = sts.out_valid;
  assign out_tdata  = {1'b0, res_empty, res_tail, res_head, res_count, res_data, res_ok};

endmodule

/* rtl/core/iss_checker.sv */
module iss_checker
  import iss_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[102] == (out_tdata[37:33] == 5'd0))
    else $error("empty flag disagrees with count");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[102] |-> out_tdata[69:38] == 32'd0 && out_tdata[101:70] == 32'd0)
    else $error("head or tail nonzero on empty store");

  a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[32:1] == 32'd0)
    else $error("data nonzero on rejected request");

  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[37:33] == 5'd1 |-> out_tdata[69:38] == out_tdata[101:70])
    else $error("head and tail differ with one value held");

endmodule

bind indexed_sequence_store iss_checker u_iss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* bench/indexed_sequence_store_tb.sv */
`timescale 1ns / 100ps

module indexed_sequence_store_tb;
  import iss_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_REQUESTS = 1800;
  localparam int PHASE_LEN = 200;
  localparam int QUIET_LIMIT = 500;

  typedef struct packed {
    logic              is_empty;
    logic signed [31:0] tail_value;
    logic signed [31:0] head_value;
    logic [4:0]        count;
    logic signed [31:0] data_out;
    logic              ok;
  } cmd_result_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [4:0]        position;
    logic signed [31:0] item_value;
    logic              pinned;
    cmd_result_t       result;
  } directed_row_t;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam cmd_result_t REJECT_EMPTY = '{is_empty: 1'b1, default: '0};
  localparam cmd_result_t NO_CHECK = '0;

  localparam int DIRECTED_ROWS = 22;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{CMD_DEL_FIRST, 5'd0,  32'sd0,          1'b1, REJECT_EMPTY},
    '{CMD_DEL_LAST,  5'd0,  32'sd0,          1'b1, REJECT_EMPTY},
    '{CMD_DEL_AT,    5'd0,  32'sd0,          1'b1, REJECT_EMPTY},
    '{CMD_READ,      5'd0,  32'sd0,          1'b1, REJECT_EMPTY},
    '{CMD_WRITE,     5'd0,  -32'sd1,         1'b1, REJECT_EMPTY},
    '{CMD_INS_AT,    5'd1,  32'sd5,          1'b1, REJECT_EMPTY},
    '{CMD_INS_AT,    5'd0,  VAL_MAX,         1'b1,
      '{ok: 1'b1, count: 5'd1, head_value: VAL_MAX, tail_value: VAL_MAX, default: '0}},
    '{CMD_APPEND,    5'd0,  VAL_MIN,         1'b1,
      '{ok: 1'b1, count: 5'd2, head_value: VAL_MAX, tail_value: VAL_MIN, default: '0}},
    '{CMD_PREPEND,   5'd31, -32'sd1,         1'b0, NO_CHECK},
    '{CMD_INS_AT,    5'd3,  32'sh5555_5555,  1'b0, NO_CHECK},
    '{CMD_INS_AT,    5'd5,  32'sd7,          1'b0, NO_CHECK},
    '{CMD_READ,      5'd16, 32'sd0,          1'b0, NO_CHECK},
    '{CMD_WRITE,     5'd3,  32'shAAAA_AAAA,  1'b0, NO_CHECK},
    '{CMD_READ,      5'd3,  32'sd0,          1'b0, NO_CHECK},
    '{CMD_READ,      5'd4,  32'sd0,          1'b0, NO_CHECK},
    '{CMD_DEL_AT,    5'd1,  32'sd0,          1'b0, NO_CHECK},
    '{CMD_DEL_AT,    5'd3,  32'sd0,          1'b0, NO_CHECK},
    '{CMD_INS_AT,    5'd1,  32'sd0,          1'b0, NO_CHECK},
    '{CMD_DEL_AT,    5'd0,  32'sd0,          1'b0, NO_CHECK},
    '{CMD_DEL_FIRST, 5'd0,  32'sd0,          1'b0, NO_CHECK},
    '{CMD_DEL_LAST,  5'd0,  32'sd0,          1'b0, NO_CHECK},
    '{CMD_DEL_LAST,  5'd0,  32'sd0,          1'b0, NO_CHECK}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [CMD_W-1:0]       in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic signed [31:0] store_slots [DEPTH];
  int                 store_held = 0;
  cmd_result_t        expected_results [$];
  int                 failures = 0;
  int                 quiet_cycles = 0;
  logic               steady_flow = 1'b0;

  indexed_sequence_store #(.DEPTH(DEPTH)) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic cmd_result_t apply_command(input cmd_t cmd, input logic [4:0] position,
                                                input logic signed [31:0] item_value);
    cmd_result_t r;
    logic        full;
    int          pos;
    int          k;
    r = '0;
    pos = int'(position);
    full = store_held >= DEPTH;
    case (cmd)
      CMD_APPEND: begin
        if (!full) begin
          store_slots[store_held] = item_value;
          store_held++;
          r.ok = 1'b1;
        end
      end
      CMD_PREPEND, CMD_INS_AT: begin
        if (cmd == CMD_PREPEND) pos = 0;
        if (!full && pos <= store_held) begin
          for (k = store_held; k > pos; k--) store_slots[k] = store_slots[k-1];
          store_slots[pos] = item_value;
          store_held++;
          r.ok = 1'b1;
        end
      end
      CMD_DEL_FIRST, CMD_DEL_LAST, CMD_DEL_AT: begin
        if (cmd == CMD_DEL_FIRST) pos = 0;
        if (cmd == CMD_DEL_LAST) pos = store_held - 1;
        if (pos >= 0 && pos < store_held) begin
          r.data_out = store_slots[pos];
          for (k = pos; k + 1 < store_held; k++) store_slots[k] = store_slots[k+1];
          store_held--;
          r.ok = 1'b1;
        end
      end
      CMD_READ: begin
        if (pos < store_held) begin
          r.data_out = store_slots[pos];
          r.ok = 1'b1;
        end
      end
      CMD_WRITE: begin
        if (pos < store_held) begin
          store_slots[pos] = item_value;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = 5'(store_held);
    if (store_held > 0) begin
      r.head_value = store_slots[0];
      r.tail_value = store_slots[store_held-1];
    end else begin
      r.is_empty = 1'b1;
    end
    return r;
  endfunction

  task automatic send_request(input cmd_t cmd, input logic [4:0] position,
                              input logic signed [31:0] item_value,
                              output cmd_result_t predicted);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, item_value, position};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    predicted = apply_command(cmd, position, item_value);
  endtask

  initial begin
    cmd_result_t        predicted;
    cmd_t               cmd;
    logic [4:0]         position;
    logic signed [31:0] item_value;
    int                 phase;
    int                 mode;
    int                 pick;
    int                 limit;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_APPEND;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_request(DIRECTED[i].cmd, DIRECTED[i].position, DIRECTED[i].item_value, predicted);
      expected_results.push_back(DIRECTED[i].pinned ? DIRECTED[i].result : predicted);
    end

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % PHASE_LEN == 0) begin
        phase = i / PHASE_LEN;
        in_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        steady_flow <= (phase == 4 || phase == 7);
        @(posedge clk);
      end
      mode = phase % 3;
      pick = $urandom_range(0, 99);
      case (mode)
        0: pick = (pick < 60) ? 0 : (pick < 70) ? 1 : 2;
        1: pick = $urandom_range(0, 2);
        default: pick = (pick < 15) ? 0 : (pick < 70) ? 1 : 2;
      endcase
      case (pick)
        0: begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_APPEND;
            1: cmd = CMD_PREPEND;
            default: cmd = CMD_INS_AT;
          endcase
        end
        1: begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_DEL_FIRST;
            1: cmd = CMD_DEL_LAST;
            default: cmd = CMD_DEL_AT;
          endcase
        end
        default: cmd = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
      endcase
      limit = (cmd == CMD_INS_AT) ? store_held : (store_held > 0 ? store_held - 1 : 0);
      if (limit > 16) limit = 16;
      if ($urandom_range(0, 3) == 0) position = 5'($urandom_range(0, 16));
      else position = 5'($urandom_range(0, limit));
      item_value = $urandom;
      send_request(cmd, position, item_value, predicted);
      expected_results.push_back(predicted);
    end

    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (failures == 0 && expected_results.size() == 0) begin
      $display("indexed_sequence_store_tb OK");
    end else begin
      $display("indexed_sequence_store_tb NOT OK");
    end
    $finish;
  end

  initial begin
    int stall;
    forever begin
      stall = steady_flow ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_tvalid));
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_val), $signed(act_val));
      failures++;
    end
  endfunction

  always @(posedge clk) begin
    cmd_result_t got;
    cmd_result_t exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = cmd_result_t'(out_tdata[$bits(cmd_result_t)-1:0]);
      if (expected_results.size() == 0) begin
        $error("result with no request waiting");
        failures++;
      end else begin
        exp = expected_results.pop_front();
        compare_field("ok", 32'(exp.ok), 32'(got.ok));
        compare_field("data_out", exp.data_out, got.data_out);
        compare_field("count", 32'(exp.count), 32'(got.count));
        compare_field("head_value", exp.head_value, got.head_value);
        compare_field("tail_value", exp.tail_value, got.tail_value);
        compare_field("is_empty", 32'(exp.is_empty), 32'(got.is_empty));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("indexed_sequence_store_tb NOT OK");
      $finish;
    end
  end

endmodule

/* files.f */
rtl/core/iss_pkg.sv
rtl/core/iss_ctrl.sv
rtl/core/iss_dpath.sv
rtl/core/indexed_sequence_store.sv
rtl/core/iss_checker.sv
bench/indexed_sequence_store_tb.sv
